/* hw/rtl/u8rf_pkg.sv */
// ----------------------------------------------------------------------------
// u8rf_pkg: shared types and constants
// Opcodes, register indexes, reset values and the structs passed between
// the receiver, the transmitter and the receive FIFO.
// ----------------------------------------------------------------------------
package u8rf_pkg;

   // item opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_SEND  = 2'd2;
   localparam logic [1:0] OP_FLUSH = 2'd3;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_RX_CENTER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RX_BIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RX_STOP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TX_BIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TX_EXTRA  = 3'd4;

   // register reset values
   localparam logic [15:0] RST_RX_CENTER = 16'd114;
   localparam logic [15:0] RST_RX_BIT    = 16'd236;
   localparam logic [15:0] RST_RX_STOP   = 16'd236;
   localparam logic [15:0] RST_TX_BIT    = 16'd233;
   localparam logic [7:0]  RST_TX_EXTRA  = 8'd5;

   localparam int unsigned COUNT_W = 6;

   typedef struct packed {
      logic [15:0] center_delay;
      logic [15:0] bit_delay;
      logic [15:0] stop_delay;
   } rx_cfg_type;

   typedef struct packed {
      logic [15:0] bit_delay;
      logic [7:0]  start_extra;
   } tx_cfg_type;

   // byte finished by the receiver on this item
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } rx_store_type;

endpackage

/* hw/rtl/u8rf_ram.sv */
// ----------------------------------------------------------------------------
// u8rf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// Read data holds while re is low.
// ----------------------------------------------------------------------------
module u8rf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/u8rf_fifo.sv */
// ----------------------------------------------------------------------------
// u8rf_fifo: receive ring FIFO
// Head/tail pointers around a RAM of DEPTH entries, DEPTH-1 usable.
// Store happens before pop/flush within an item; a byte stored and popped
// on the same item is forwarded around the RAM.
// ----------------------------------------------------------------------------
module u8rf_fifo #(
   parameter int DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [1:0]                     op,
   input  u8rf_pkg::rx_store_type         store,
   output logic                           pop_valid,
   output logic [u8rf_pkg::COUNT_W-1:0]   count,
   output logic [7:0]                     rd_data
);
   import u8rf_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW-1:0] tail_inc, head_inc, tail_rx;
   logic          full, wr_en;
   logic          byp_ff, byp_in;
   logic [7:0]    byp_data_ff;
   logic [7:0]    ram_rdata;
   logic [8:0]    span, span_wrap;

   assign tail_inc = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign full     = (tail_inc == head_ff);
   assign wr_en    = step && store.valid && !full;
   assign tail_rx  = (store.valid && !full) ? tail_inc : tail_ff;

   assign pop_valid = (op == OP_POP) && (head_ff != tail_rx);

   always_comb begin
      head_in = head_ff;
      tail_in = tail_rx;
      case (op)
         OP_POP: begin
            if (pop_valid) head_in = head_inc;
         end
         OP_FLUSH: begin
            head_in = '0;
            tail_in = '0;
         end
         default: ;
      endcase
   end

   // entry read at head is being written on this same item
   assign byp_in = wr_en && (tail_ff == head_ff);

   assign span      = 9'(tail_in) + 9'(DEPTH) - 9'(head_in);
   assign span_wrap = (span >= 9'(DEPTH)) ? span - 9'(DEPTH) : span;
   assign count     = span_wrap[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         byp_ff  <= 1'b0;
      end else if (step) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         byp_ff  <= byp_in;
      end
      if (step) begin
         byp_data_ff <= store.data;
      end
   end

   u8rf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (tail_ff),
      .wdata (store.data),
      .re    (step),
      .raddr (head_ff),
      .rdata (ram_rdata)
   );

   assign rd_data = byp_ff ? byp_data_ff : ram_rdata;

endmodule

/* hw/rtl/u8rf_rx.sv */
// ----------------------------------------------------------------------------
// u8rf_rx: 8N1 receiver
// Start detect, centering wait, eight samples LSB first, unchecked stop wait.
// Advances once per accepted item.
// ----------------------------------------------------------------------------
module u8rf_rx (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   level,
   input  u8rf_pkg::rx_cfg_type   cfg,
   output u8rf_pkg::rx_store_type store,
   output logic                   busy
);
   import u8rf_pkg::*;

   typedef enum logic [1:0] {
      RX_IDLE,
      RX_FIRST,
      RX_DATA,
      RX_STOP
   } rx_state_type;

   rx_state_type state_ff, state_in;
   logic [15:0]  timer_ff, timer_in;
   logic [2:0]   index_ff, index_in;
   logic [7:0]   shift_ff, shift_in;
   logic         fire;

   assign fire = (timer_ff <= 16'd1);

   always_comb begin
      state_in    = state_ff;
      timer_in    = fire ? timer_ff : timer_ff - 1'b1;
      index_in    = index_ff;
      shift_in    = shift_ff;
      store.valid = 1'b0;
      store.data  = shift_ff;
      case (state_ff)
         RX_IDLE: begin
            timer_in = timer_ff;
            if (!level) begin
               state_in = RX_FIRST;
               timer_in = cfg.center_delay;
               index_in = '0;
               shift_in = '0;
            end
         end
         RX_FIRST: begin
            if (fire) begin
               state_in = RX_DATA;
               timer_in = cfg.bit_delay;
            end
         end
         RX_DATA: begin
            if (fire) begin
               shift_in[index_ff] = shift_ff[index_ff] | level;
               if (index_ff == 3'd7) begin
                  state_in = RX_STOP;
                  timer_in = cfg.stop_delay;
                  index_in = '0;
               end else begin
                  index_in = index_ff + 1'b1;
                  timer_in = cfg.bit_delay;
               end
            end
         end
         RX_STOP: begin
            if (fire) begin
               store.valid = 1'b1;
               state_in    = RX_IDLE;
               timer_in    = '0;
            end
         end
         default: state_in = RX_IDLE;
      endcase
   end

   assign busy = (state_in != RX_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RX_IDLE;
         timer_ff <= '0;
         index_ff <= '0;
         shift_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
         timer_ff <= timer_in;
         index_ff <= index_in;
         shift_ff <= shift_in;
      end
   end

endmodule

/* hw/rtl/u8rf_tx.sv */
// ----------------------------------------------------------------------------
// u8rf_tx: 8N1 transmitter
// Stretched start bit, eight data bits LSB first, one stop bit time.
// The bit timer advances before a send is checked on the same item.
// ----------------------------------------------------------------------------
module u8rf_tx (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 send,
   input  logic [7:0]           tx_byte,
   input  u8rf_pkg::tx_cfg_type cfg,
   output logic                 line,
   output logic                 accepted,
   output logic                 busy
);
   import u8rf_pkg::*;

   typedef enum logic [1:0] {
      TX_IDLE,
      TX_FIRST,
      TX_DATA,
      TX_STOP
   } tx_state_type;

   tx_state_type state_ff, state_in;
   logic [16:0]  timer_ff, timer_in;
   logic [2:0]   index_ff, index_in;
   logic [7:0]   shift_ff, shift_in;
   logic         out_ff, out_in;
   logic         fire;

   assign fire = (timer_ff <= 17'd1);

   always_comb begin
      state_in = state_ff;
      timer_in = fire ? timer_ff : timer_ff - 1'b1;
      index_in = index_ff;
      shift_in = shift_ff;
      out_in   = out_ff;
      accepted = 1'b0;
      case (state_ff)
         TX_IDLE: timer_in = timer_ff;
         TX_FIRST: begin
            if (fire) begin
               state_in = TX_DATA;
               index_in = '0;
               out_in   = shift_ff[0];
               timer_in = 17'(cfg.bit_delay);
            end
         end
         TX_DATA: begin
            if (fire) begin
               if (index_ff == 3'd7) begin
                  state_in = TX_STOP;
                  index_in = '0;
                  out_in   = 1'b1;
               end else begin
                  index_in = index_ff + 1'b1;
                  out_in   = shift_ff[index_ff + 1'b1];
               end
               timer_in = 17'(cfg.bit_delay);
            end
         end
         TX_STOP: begin
            if (fire) begin
               state_in = TX_IDLE;
               timer_in = '0;
            end
         end
         default: state_in = TX_IDLE;
      endcase

      if (send && state_in == TX_IDLE && cfg.bit_delay != 16'd0) begin
         accepted = 1'b1;
         state_in = TX_FIRST;
         shift_in = tx_byte;
         index_in = '0;
         out_in   = 1'b0;
         timer_in = 17'(cfg.bit_delay) + 17'(cfg.start_extra);
      end
   end

   assign line = out_in;
   assign busy = (state_in != TX_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TX_IDLE;
         timer_ff <= '0;
         index_ff <= '0;
         shift_ff <= '0;
         out_ff   <= 1'b1;
      end else if (step) begin
         state_ff <= state_in;
         timer_ff <= timer_in;
         index_ff <= index_in;
         shift_ff <= shift_in;
         out_ff   <= out_in;
      end
   end

endmodule

/* hw/rtl/uart_8n1_with_rx_fifo_top.sv */
// ----------------------------------------------------------------------------
// uart_8n1_with_rx_fifo_top: 8N1 serial port with receive FIFO
// One item per line sample tick; receiver, transmitter and RAM-based FIFO.
//
//   channel | dir | handshake              | contents
//   req     | in  | req_tvalid/req_tready  | tuser opcode, tdata rx_level, tx_byte
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata line, pop and status fields
//   csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// One item per clock while rsp is not stalled; from req to rsp an item passes
// the registered read of the FIFO RAM and then the output register.
// Reset is synchronous; no clearing pass, the pointers reset to empty.
// A stalled rsp holds the output register; req keeps flowing until the
// read stage behind it is also full.
// ----------------------------------------------------------------------------
module uart_8n1_with_rx_fifo_top #(
   parameter int RX_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // rx_level, tx_byte[8:1], zeros
   input  logic [1:0]                        req_tuser,  // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // tx_line, pop_valid, pop_data,
                                                         // rx_count, send_accepted,
                                                         // tx_busy, rx_busy, zeros
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [u8rf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [15:0]                       csr_data
);
   import u8rf_pkg::*;

   rx_cfg_type   rx_cfg_ff;
   tx_cfg_type   tx_cfg_ff;
   rx_store_type store;

   logic               step;
   logic               s1_move;
   logic [1:0]         op;
   logic               rx_busy, tx_line, tx_acc, tx_busy, pop_valid;
   logic [COUNT_W-1:0] count;
   logic [7:0]         rd_data;

   // read stage: everything but the popped byte, which arrives from the RAM
   logic               s1_valid_ff;
   logic               s1_line_ff, s1_pop_ff, s1_acc_ff, s1_txb_ff, s1_rxb_ff;
   logic [COUNT_W-1:0] s1_count_ff;

   logic               out_valid_ff;
   logic [23:0]        out_data_ff, out_data_in;

   assign op = req_tuser;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_cfg_ff.center_delay <= RST_RX_CENTER;
         rx_cfg_ff.bit_delay    <= RST_RX_BIT;
         rx_cfg_ff.stop_delay   <= RST_RX_STOP;
         tx_cfg_ff.bit_delay    <= RST_TX_BIT;
         tx_cfg_ff.start_extra  <= RST_TX_EXTRA;
      end else if (csr_valid) begin
         case (csr_index)
            REG_RX_CENTER: rx_cfg_ff.center_delay <= csr_data;
            REG_RX_BIT:    rx_cfg_ff.bit_delay    <= csr_data;
            REG_RX_STOP:   rx_cfg_ff.stop_delay   <= csr_data;
            REG_TX_BIT:    tx_cfg_ff.bit_delay    <= csr_data;
            REG_TX_EXTRA:  tx_cfg_ff.start_extra  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // flow control
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign step       = req_tvalid && req_tready;

   u8rf_rx u_rx (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .level (req_tdata[0]),
      .cfg   (rx_cfg_ff),
      .store (store),
      .busy  (rx_busy)
   );

   u8rf_fifo #(
      .DEPTH (RX_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .op        (op),
      .store     (store),
      .pop_valid (pop_valid),
      .count     (count),
      .rd_data   (rd_data)
   );

   u8rf_tx u_tx (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .send     (op == OP_SEND),
      .tx_byte  (req_tdata[8:1]),
      .cfg      (tx_cfg_ff),
      .line     (tx_line),
      .accepted (tx_acc),
      .busy     (tx_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (step) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
      if (step) begin
         s1_line_ff  <= tx_line;
         s1_pop_ff   <= pop_valid;
         s1_count_ff <= count;
         s1_acc_ff   <= tx_acc;
         s1_txb_ff   <= tx_busy;
         s1_rxb_ff   <= rx_busy;
      end
   end

   always_comb begin
      out_data_in        = '0;
      out_data_in[0]     = s1_line_ff;
      out_data_in[1]     = s1_pop_ff;
      out_data_in[9:2]   = s1_pop_ff ? rd_data : 8'd0;
      out_data_in[15:10] = s1_count_ff;
      out_data_in[16]    = s1_acc_ff;
      out_data_in[17]    = s1_txb_ff;
      out_data_in[18]    = s1_rxb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("item accepted while both pipeline stages are held");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (step && op == OP_FLUSH) |=> (s1_count_ff == '0))
      else $error("receive FIFO not empty after flush");

   a_accept_implies_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff[16]) |-> out_data_ff[17])
      else $error("send accepted without transmitter busy");

   a_accept_only_on_send: assert property (@(posedge clock) disable iff (reset)
      (step && tx_acc) |-> (op == OP_SEND))
      else $error("send accepted for a non-send opcode");

endmodule
